[hw/rtl/four_voice_sample_mixer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the four voice sample mixer
// Property wrappers for the RTL file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef FOUR_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH
`define FOUR_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define FVSM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fvsm assertion failed");

// next-cycle implication
`define FVSM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fvsm assertion failed");

`endif

[hw/rtl/fvsm_pkg.sv]
// ----------------------------------------------------------------------------
// fvsm_pkg
// Widths, codes, reset values and shared types of the sample mixer.
// ----------------------------------------------------------------------------
package fvsm_pkg;

   localparam int STEP_W    = 36;
   localparam int MASK_W    = 4;
   localparam int KIND_W    = 2;
   localparam int VOICE_W   = 2;
   localparam int ADDR_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 16;
   localparam int PER_W     = 16;
   localparam int VOL_IN_W  = 8;
   localparam int VOL_W     = 7;
   localparam int OUT_W     = 14;
   localparam int END_W     = 17;
   localparam int DVD_W     = 36;
   localparam int DVS_W     = 21;
   localparam int ACC_W     = 18;
   localparam int CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SET    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RENDER = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_NUM = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EN_MASK  = 1'd1;

   localparam logic [STEP_W-1:0] STEP_RESET = 36'd5270959;
   localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;
   localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd64;

   localparam int DEF_SAMPLE_MEM_DEPTH = 65536;
   localparam int DEF_FRAC_BITS        = 16;
   localparam int DEF_VOICES           = 4;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

[hw/rtl/fvsm_req_if.sv]
// ----------------------------------------------------------------------------
// fvsm_req_if
// Request channel: one command beat per handshake.
// ----------------------------------------------------------------------------
interface fvsm_req_if import fvsm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic [VOICE_W-1:0]         voice;
   logic [ADDR_W-1:0]          address;
   logic signed [BYTE_W-1:0]   data_byte;
   logic [LEN_W-1:0]           length;
   logic [LEN_W-1:0]           rpt_offset;
   logic [LEN_W-1:0]           rpt_length;
   logic [PER_W-1:0]           period;
   logic [VOL_IN_W-1:0]        volume;

   modport source (output valid, kind, voice, address, data_byte, length, rpt_offset,
                   rpt_length, period, volume, input ready);
   modport sink   (input valid, kind, voice, address, data_byte, length, rpt_offset,
                   rpt_length, period, volume, output ready);
endinterface

[hw/rtl/fvsm_rsp_if.sv]
// ----------------------------------------------------------------------------
// fvsm_rsp_if
// Response channel: one stereo frame beat per handshake.
// ----------------------------------------------------------------------------
interface fvsm_rsp_if import fvsm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [OUT_W-1:0]  left_sample;
   logic signed [OUT_W-1:0]  right_sample;
   logic [MASK_W-1:0]        active_mask;

   modport source (output valid, left_sample, right_sample, active_mask, input ready);
   modport sink   (input valid, left_sample, right_sample, active_mask, output ready);
endinterface

[hw/rtl/fvsm_div.sv]
// ----------------------------------------------------------------------------
// fvsm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fvsm_div import fvsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[hw/rtl/fvsm_sample_ram.sv]
// ----------------------------------------------------------------------------
// fvsm_sample_ram
// Byte-wide sample memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module fvsm_sample_ram import fvsm_pkg::*; #(
   parameter int DEPTH = DEF_SAMPLE_MEM_DEPTH,
   parameter int AW    = $clog2(DEF_SAMPLE_MEM_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/four_voice_sample_mixer_core.sv]
// ----------------------------------------------------------------------------
// four_voice_sample_mixer_core
// Multi-voice sample playback mixer, voices visited in turn by a sequencer.
//
//   port   dir  beat
//   req    in   write byte / start voice / set period+volume / render frame
//   rsp    out  left, right, active mask (render only)
//   csr_*  in   step numerator, voice enable mask
//
// Write goes through S_WRITE, after an address reduction in S_WADDR when the
// memory depth is not a power of two. Start and set complete in S_IDLE. Render
// skips disabled voices, fetches, scales and steps audible ones (no fetch once
// past the end) and divides again when a looping voice wraps; the 36-step shared divider dominates.
// Reset clears voice state and control registers; datapath registers and sample memory are not cleared.
// A finished frame waits in the output register until rsp.ready.
// ----------------------------------------------------------------------------
`include "four_voice_sample_mixer_core_macros.svh"

module four_voice_sample_mixer_core import fvsm_pkg::*; #(
   parameter int SAMPLE_MEM_DEPTH = DEF_SAMPLE_MEM_DEPTH,
   parameter int FRAC_BITS        = DEF_FRAC_BITS,
   parameter int VOICES           = DEF_VOICES
) (
   input  logic                 clock,
   input  logic                 reset,
   fvsm_req_if.sink             req,
   fvsm_rsp_if.source           rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STEP_W-1:0]    csr_write_data
);

   localparam int  AW       = $clog2(SAMPLE_MEM_DEPTH);
   localparam bit  MEM_POW2 = (SAMPLE_MEM_DEPTH & (SAMPLE_MEM_DEPTH - 1)) == 0;
   localparam int  POS_W    = END_W + FRAC_BITS;
   localparam int  PSUM_W   = ((STEP_W > POS_W) ? STEP_W : POS_W) + 1;
   localparam int  NP_W     = PSUM_W - FRAC_BITS;
   localparam int  VI_W     = $clog2(VOICES + 1);
   localparam int  VX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int  RED_W    = AW + 8;

   localparam logic [2:0] RED_TOP = 3'd7;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_WADDR = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_VSEL  = 4'd3;
   localparam logic [3:0] S_RADDR = 4'd4;
   localparam logic [3:0] S_RREAD = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_STEP  = 4'd8;
   localparam logic [3:0] S_WRAP  = 4'd9;
   localparam logic [3:0] S_MOD   = 4'd10;
   localparam logic [3:0] S_NEXT  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]              st_ff, st_in;
   logic [VI_W-1:0]         vi_ff, vi_in;
   logic [STEP_W-1:0]       step_num_ff, step_num_in;
   logic [MASK_W-1:0]       en_mask_ff, en_mask_in;

   logic [POS_W-1:0]        pos_ff [VOICES];
   logic [POS_W-1:0]        pos_in [VOICES];
   logic [ADDR_W-1:0]       base_ff [VOICES];
   logic [ADDR_W-1:0]       base_in [VOICES];
   logic [END_W-1:0]        end_ff [VOICES];
   logic [END_W-1:0]        end_in [VOICES];
   logic [LEN_W-1:0]        lstart_ff [VOICES];
   logic [LEN_W-1:0]        lstart_in [VOICES];
   logic [LEN_W-1:0]        llen_ff [VOICES];
   logic [LEN_W-1:0]        llen_in [VOICES];
   logic [PER_W-1:0]        per_ff [VOICES];
   logic [PER_W-1:0]        per_in [VOICES];
   logic [VOL_W-1:0]        vol_ff [VOICES];
   logic [VOL_W-1:0]        vol_in [VOICES];
   logic [VOICES-1:0]       act_ff, act_in;

   logic signed [ACC_W-1:0] left_ff, left_in;
   logic signed [ACC_W-1:0] right_ff, right_in;
   logic signed [15:0]      prod_ff, prod_in;
   logic [PSUM_W-1:0]       sum_ff, sum_in;
   logic [AW-1:0]           maddr_ff, maddr_in;
   logic [BYTE_W-1:0]       wdata_ff, wdata_in;
   logic [RED_W-1:0]        red_ff, red_in;
   logic [2:0]              red_k_ff, red_k_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        rsp_left_ff, rsp_left_in;
   logic [OUT_W-1:0]        rsp_right_ff, rsp_right_in;
   logic [MASK_W-1:0]       rsp_mask_ff, rsp_mask_in;

   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic [BYTE_W-1:0]       ram_rdata;
   logic                    ram_we;

   logic [VOICES-1:0]       en_full;
   logic [VOICES-1:0]       pan_left;
   logic [VX_W-1:0]         vx;
   logic [VX_W-1:0]         req_vx;
   logic [END_W-1:0]        ipos;
   logic [NP_W-1:0]         npos;
   logic [DVD_W-1:0]        raddr_src;
   logic [DVD_W-1:0]        waddr_src;
   logic [END_W-1:0]        wrap_pos;
   logic [RED_W-1:0]        red_sub;
   logic [RED_W-1:0]        red_nx;
   logic signed [ACC_W-1:0] l_half, r_half;
   logic [MASK_W-1:0]       act_mask;
   logic                    req_fire;

   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         en_full[i]  = (i >= MASK_W) ? 1'b1 : en_mask_ff[i[1:0]];
         pan_left[i] = (i[1:0] == 2'd0) || (i[1:0] == 2'd3);
      end
      act_mask = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (i < VOICES) begin
            act_mask[i] = act_ff[i];
         end
      end
   end

   assign vx        = vi_ff[VX_W-1:0];
   assign req_vx    = VX_W'(req.voice);
   assign ipos      = pos_ff[vx][POS_W-1:FRAC_BITS];
   assign npos      = sum_ff[PSUM_W-1:FRAC_BITS];
   assign raddr_src = DVD_W'(base_ff[vx]) + DVD_W'(ipos);
   assign waddr_src = DVD_W'(req.address);
   assign wrap_pos  = END_W'(lstart_ff[vx]) + END_W'(div_rsp.remainder[LEN_W-1:0]);
   // address reduction: compare and subtract depth << k, k from 7 down to 0
   assign red_sub   = RED_W'(SAMPLE_MEM_DEPTH) << red_k_ff;
   assign red_nx    = (red_ff >= red_sub) ? RED_W'(red_ff - red_sub) : red_ff;
   assign l_half    = left_ff >>> 1;
   assign r_half    = right_ff >>> 1;
   assign req_fire  = req.valid && req.ready;
   assign ram_we    = (st_ff == S_WRITE);

   always_comb begin
      st_in        = st_ff;
      vi_in        = vi_ff;
      step_num_in  = step_num_ff;
      en_mask_in   = en_mask_ff;
      pos_in       = pos_ff;
      base_in      = base_ff;
      end_in       = end_ff;
      lstart_in    = lstart_ff;
      llen_in      = llen_ff;
      per_in       = per_ff;
      vol_in       = vol_ff;
      act_in       = act_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      maddr_in     = maddr_ff;
      wdata_in     = wdata_ff;
      red_in       = red_ff;
      red_k_in     = red_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_mask_in  = rsp_mask_ff;
      div_req      = '0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_NUM: step_num_in = csr_write_data;
            CSR_EN_MASK:  en_mask_in  = csr_write_data[MASK_W-1:0];
            default:      ;
         endcase
      end

      case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req.kind)
                  KIND_WRITE: begin
                     wdata_in = req.data_byte;
                     if (MEM_POW2) begin
                        maddr_in = waddr_src[AW-1:0];
                        st_in    = S_WRITE;
                     end else begin
                        red_in   = RED_W'(req.address);
                        red_k_in = RED_TOP;
                        st_in    = S_WADDR;
                     end
                  end
                  KIND_START: begin
                     if (32'(req.voice) < VOICES) begin
                        base_in[req_vx]   = req.address;
                        pos_in[req_vx]    = '0;
                        llen_in[req_vx]   = req.rpt_length;
                        lstart_in[req_vx] = (req.rpt_length != '0) ? req.rpt_offset : '0;
                        end_in[req_vx]    = (req.rpt_length != '0)
                           ? END_W'(req.rpt_offset) + END_W'(req.rpt_length)
                           : END_W'(req.length);
                        vol_in[req_vx]    = '0;
                        act_in[req_vx]    = 1'b1;
                     end
                  end
                  KIND_SET: begin
                     if (32'(req.voice) < VOICES) begin
                        per_in[req_vx] = req.period;
                        vol_in[req_vx] = (req.volume > VOL_IN_W'(VOL_MAX))
                           ? VOL_MAX : req.volume[VOL_W-1:0];
                     end
                  end
                  KIND_RENDER: begin
                     vi_in    = '0;
                     left_in  = '0;
                     right_in = '0;
                     st_in    = S_VSEL;
                  end
                  default: ;
               endcase
            end
         end
         S_WADDR: begin
            red_in   = red_nx;
            red_k_in = red_k_ff - 1'b1;
            if (red_k_ff == '0) begin
               maddr_in = red_nx[AW-1:0];
               st_in    = S_WRITE;
            end
         end
         S_WRITE: begin
            st_in = S_IDLE;
         end
         S_VSEL: begin
            if (vi_ff == VI_W'(VOICES)) begin
               st_in = S_OUT;
            end else if (!act_ff[vx] || !en_full[vx] || (per_ff[vx] == '0)) begin
               vi_in = vi_ff + 1'b1;
            end else if (ipos < end_ff[vx]) begin
               if (MEM_POW2) begin
                  maddr_in = raddr_src[AW-1:0];
                  st_in    = S_RREAD;
               end else begin
                  red_in   = RED_W'(raddr_src);
                  red_k_in = RED_TOP;
                  st_in    = S_RADDR;
               end
            end else begin
               prod_in = '0;
               st_in   = S_ACC;
            end
         end
         S_RADDR: begin
            red_in   = red_nx;
            red_k_in = red_k_ff - 1'b1;
            if (red_k_ff == '0) begin
               maddr_in = red_nx[AW-1:0];
               st_in    = S_RREAD;
            end
         end
         S_RREAD: begin
            st_in = S_MUL;
         end
         S_MUL: begin
            prod_in = $signed(ram_rdata) * $signed({1'b0, vol_ff[vx]});
            st_in   = S_ACC;
         end
         S_ACC: begin
            if (pan_left[vx]) begin
               left_in = left_ff + ACC_W'(prod_ff);
            end else begin
               right_in = right_ff + ACC_W'(prod_ff);
            end
            div_req.start    = 1'b1;
            div_req.dividend = step_num_ff;
            div_req.divisor  = DVS_W'(per_ff[vx]);
            st_in            = S_STEP;
         end
         S_STEP: begin
            if (div_rsp.done) begin
               sum_in = PSUM_W'(pos_ff[vx]) + PSUM_W'(div_rsp.quotient);
               st_in  = S_WRAP;
            end
         end
         S_WRAP: begin
            if (npos >= NP_W'(end_ff[vx])) begin
               if (llen_ff[vx] != '0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DVD_W'(NP_W'(npos - NP_W'(end_ff[vx])));
                  div_req.divisor  = DVS_W'(llen_ff[vx]);
                  st_in            = S_MOD;
               end else begin
                  act_in[vx] = 1'b0;
                  st_in      = S_NEXT;
               end
            end else begin
               pos_in[vx] = sum_ff[POS_W-1:0];
               st_in      = S_NEXT;
            end
         end
         S_MOD: begin
            if (div_rsp.done) begin
               pos_in[vx] = {wrap_pos, {FRAC_BITS{1'b0}}};
               st_in      = S_NEXT;
            end
         end
         S_NEXT: begin
            vi_in = vi_ff + 1'b1;
            st_in = S_VSEL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = act_mask;
               if (l_half > ACC_W'(8191)) begin
                  rsp_left_in = OUT_W'(8191);
               end else if (l_half < -ACC_W'(8192)) begin
                  rsp_left_in = OUT_W'(-8192);
               end else begin
                  rsp_left_in = l_half[OUT_W-1:0];
               end
               if (r_half > ACC_W'(8191)) begin
                  rsp_right_in = OUT_W'(8191);
               end else if (r_half < -ACC_W'(8192)) begin
                  rsp_right_in = OUT_W'(-8192);
               end else begin
                  rsp_right_in = r_half[OUT_W-1:0];
               end
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         vi_ff        <= '0;
         step_num_ff  <= STEP_RESET;
         en_mask_ff   <= MASK_RESET;
         act_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            pos_ff[i]    <= '0;
            base_ff[i]   <= '0;
            end_ff[i]    <= '0;
            lstart_ff[i] <= '0;
            llen_ff[i]   <= '0;
            per_ff[i]    <= '0;
            vol_ff[i]    <= '0;
         end
      end else begin
         st_ff        <= st_in;
         vi_ff        <= vi_in;
         step_num_ff  <= step_num_in;
         en_mask_ff   <= en_mask_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         base_ff      <= base_in;
         end_ff       <= end_in;
         lstart_ff    <= lstart_in;
         llen_ff      <= llen_in;
         per_ff       <= per_in;
         vol_ff       <= vol_in;
      end
      left_ff      <= left_in;
      right_ff     <= right_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      maddr_ff     <= maddr_in;
      wdata_ff     <= wdata_in;
      red_ff       <= red_in;
      red_k_ff     <= red_k_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   fvsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fvsm_sample_ram #(
      .DEPTH (SAMPLE_MEM_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (maddr_ff),
      .wr_data (wdata_ff),
      .rd_addr (maddr_ff),
      .rd_data (ram_rdata)
   );

   assign req.ready        = (st_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.left_sample  = rsp_left_ff;
   assign rsp.right_sample = rsp_right_ff;
   assign rsp.active_mask  = rsp_mask_ff;

   `FVSM_ASSERT_IMP(a_idle_div_quiet, clock, reset, st_ff == S_IDLE, !div_rsp.busy)
   `FVSM_ASSERT_IMP(a_div_done_waited, clock, reset, div_rsp.done, st_ff == S_STEP || st_ff == S_MOD)
   `FVSM_ASSERT_NXT(a_frame_loaded, clock, reset, st_ff == S_OUT && (!rsp_valid_ff || rsp.ready), rsp_valid_ff && st_ff == S_IDLE)

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: four_voice_sample_mixer_core regression
// Drives write, start, set and render commands with random gaps, mirrors the
// voice state in a local mixer model and checks every stereo frame in order.
// ----------------------------------------------------------------------------
module tb import fvsm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_DEPTH   = 65536;
   localparam int FRAC        = 16;
   localparam int NVOICE      = 4;
   localparam int STALL_LIMIT = 8000;
   localparam int DRAIN_WAIT  = 400;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [VOICE_W-1:0]       voice;
      logic [ADDR_W-1:0]        address;
      logic signed [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]         length;
      logic [LEN_W-1:0]         rpt_offset;
      logic [LEN_W-1:0]         rpt_length;
      logic [PER_W-1:0]         period;
      logic [VOL_IN_W-1:0]      volume;
   } cmd_type;

   typedef struct {
      logic signed [OUT_W-1:0] left;
      logic signed [OUT_W-1:0] right;
      logic [MASK_W-1:0]       active;
   } frame_type;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [STEP_W-1:0]    csr_write_data;

   fvsm_req_if req ();
   fvsm_rsp_if rsp ();

   four_voice_sample_mixer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // mixer model state
   logic signed [7:0] mem_byte [MEM_DEPTH];
   bit                mem_written [MEM_DEPTH];
   logic [63:0]       v_pos [NVOICE];
   logic [15:0]       v_base [NVOICE];
   logic [16:0]       v_end [NVOICE];
   logic [15:0]       v_lstart [NVOICE];
   logic [15:0]       v_llen [NVOICE];
   logic [15:0]       v_period [NVOICE];
   logic [6:0]        v_vol [NVOICE];
   bit                v_active [NVOICE];
   logic [STEP_W-1:0] step_num;
   logic [MASK_W-1:0] en_mask;

   frame_type expected_frames [$];
   int     mismatches;
   int     items_sent;
   int     idle_cycles;
   bit     idle_on;
   bit     hold_request;
   int     hold_left;
   int     rsp_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void apply_cmd(cmd_type c);
      int          v;
      int          i;
      int          left;
      int          right;
      int          s;
      logic [63:0] ipos;
      logic [63:0] npos;
      frame_type   f;
      v = c.voice;
      case (c.kind)
         KIND_WRITE: begin
            mem_byte[c.address]    = c.data_byte;
            mem_written[c.address] = 1'b1;
         end
         KIND_START: begin
            v_base[v]   = c.address;
            v_pos[v]    = '0;
            v_llen[v]   = c.rpt_length;
            v_lstart[v] = (c.rpt_length != 0) ? c.rpt_offset : '0;
            v_end[v]    = (c.rpt_length != 0) ? 17'(c.rpt_offset) + 17'(c.rpt_length)
                                              : 17'(c.length);
            v_vol[v]    = '0;
            v_active[v] = 1'b1;
         end
         KIND_SET: begin
            v_period[v] = c.period;
            v_vol[v]    = (c.volume > 8'd64) ? VOL_MAX : c.volume[6:0];
         end
         default: begin
            left  = 0;
            right = 0;
            for (i = 0; i < NVOICE; i++) begin
               if (!v_active[i] || !en_mask[i] || v_period[i] == 0) continue;
               ipos = v_pos[i] >> FRAC;
               s = 0;
               if (ipos < 64'(v_end[i]))
                  s = mem_byte[16'(v_base[i] + ipos[15:0])];
               s = s * int'(v_vol[i]);
               if (i == 0 || i == 3) left += s;
               else right += s;
               v_pos[i] = v_pos[i] + 64'(step_num) / 64'(v_period[i]);
               npos = v_pos[i] >> FRAC;
               if (npos >= 64'(v_end[i])) begin
                  if (v_llen[i] != 0) begin
                     npos = 64'(v_lstart[i]) + (npos - 64'(v_end[i])) % 64'(v_llen[i]);
                     v_pos[i] = npos << FRAC;
                  end else begin
                     v_active[i] = 1'b0;
                  end
               end
            end
            left  = left >>> 1;
            right = right >>> 1;
            if (left > 8191) left = 8191;
            if (left < -8192) left = -8192;
            if (right > 8191) right = 8191;
            if (right < -8192) right = -8192;
            f.left  = left[OUT_W-1:0];
            f.right = right[OUT_W-1:0];
            for (i = 0; i < NVOICE; i++) f.active[i] = v_active[i];
            expected_frames.push_back(f);
         end
      endcase
   endfunction

   task automatic send_cmd(cmd_type c);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      repeat (gap) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.kind       = c.kind;
      req.voice      = c.voice;
      req.address    = c.address;
      req.data_byte  = c.data_byte;
      req.length     = c.length;
      req.rpt_offset = c.rpt_offset;
      req.rpt_length = c.rpt_length;
      req.period     = c.period;
      req.volume     = c.volume;
      req.valid      = 1'b1;
      do @(posedge clock); while (!req.ready);
      apply_cmd(c);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic cmd_type blank_cmd(logic [KIND_W-1:0] k);
      cmd_type c;
      c.kind = k;
      c.voice = VOICE_W'($urandom);
      c.address = ADDR_W'($urandom);
      c.data_byte = BYTE_W'($urandom);
      c.length = LEN_W'($urandom);
      c.rpt_offset = LEN_W'($urandom);
      c.rpt_length = LEN_W'($urandom);
      c.period = PER_W'($urandom);
      c.volume = VOL_IN_W'($urandom);
      return c;
   endfunction

   task automatic write_byte(logic [15:0] a, logic [7:0] d);
      cmd_type c;
      c = blank_cmd(KIND_WRITE);
      c.address = a;
      c.data_byte = d;
      send_cmd(c);
   endtask

   task automatic start_voice(int v, logic [15:0] a, logic [15:0] len,
                              logic [15:0] ls, logic [15:0] ll);
      cmd_type c;
      c = blank_cmd(KIND_START);
      c.voice = VOICE_W'(v);
      c.address = a;
      c.length = len;
      c.rpt_offset = ls;
      c.rpt_length = ll;
      send_cmd(c);
   endtask

   task automatic set_voice(int v, logic [15:0] p, logic [7:0] vol);
      cmd_type c;
      c = blank_cmd(KIND_SET);
      c.voice = VOICE_W'(v);
      c.period = p;
      c.volume = vol;
      send_cmd(c);
   endtask

   // silence any voice that would fetch a byte never written
   task automatic render_frame();
      int          i;
      logic [63:0] ipos;
      for (i = 0; i < NVOICE; i++) begin
         if (!v_active[i] || !en_mask[i] || v_period[i] == 0) continue;
         ipos = v_pos[i] >> FRAC;
         if (ipos < 64'(v_end[i]) && !mem_written[16'(v_base[i] + ipos[15:0])])
            set_voice(i, '0, {1'b0, v_vol[i]});
      end
      send_cmd(blank_cmd(KIND_RENDER));
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [STEP_W-1:0] d);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = d;
      if (idx == CSR_STEP_NUM) step_num = d;
      else en_mask = d[MASK_W-1:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic drain();
      req.valid = 1'b0;
      wait (expected_frames.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic play_phrase();
      int          v;
      int          n;
      int          i;
      int          ls;
      int          ll;
      int          len;
      logic [15:0] a;
      logic [15:0] p;
      v = $urandom_range(0, NVOICE - 1);
      n = $urandom_range(1, 20);
      a = 16'($urandom);
      for (i = 0; i < n; i++) write_byte(a + 16'(i), 8'($urandom));
      if ($urandom_range(0, 1)) begin
         ls = $urandom_range(0, n - 1);
         ll = $urandom_range(1, n - ls);
         start_voice(v, a, 16'($urandom), 16'(ls), 16'(ll));
      end else begin
         len = $urandom_range(0, n);
         start_voice(v, a, 16'(len), 16'($urandom), '0);
      end
      case ($urandom_range(0, 9))
         0: p = 16'($urandom);
         1: p = '0;
         2: p = 16'($urandom_range(1, 20));
         default: p = 16'($urandom_range(100, 2000));
      endcase
      set_voice(v, p, 8'($urandom));
      n = $urandom_range(1, 8);
      repeat (n) render_frame();
   endtask

   task automatic random_traffic(int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if (($urandom_range(0, 199)) == 0) idle_on = ~idle_on;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: play_phrase();
            6, 7: render_frame();
            8: send_cmd(blank_cmd(KIND_START));
            default: send_cmd(blank_cmd(KIND_SET));
         endcase
      end
   endtask

   task automatic test_directed();
      int v;
      write_byte(16'hFFFF, 8'sd127);
      write_byte(16'h0000, -8'sd128);
      write_byte(16'h0001, 8'h00);
      write_byte(16'h0002, 8'h55);
      for (v = 0; v < NVOICE; v++) begin
         start_voice(v, 16'h0000, 16'd1, '0, '0);
         set_voice(v, 16'hFFFF, 8'hFF);
      end
      render_frame();
      for (v = 0; v < NVOICE; v++) start_voice(v, 16'hFFFF, 16'd1, '0, '0);
      for (v = 0; v < NVOICE; v++) set_voice(v, 16'hFFFF, 8'd65);
      render_frame();
      start_voice(0, 16'hFFFF, '0, '0, '0);
      set_voice(0, 16'd1, 8'd64);
      start_voice(1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd2);
      set_voice(1, 16'd1, 8'd64);
      start_voice(2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_voice(2, '0, 8'd64);
      render_frame();
      render_frame();
      drain();
   endtask

   task automatic test_register_sweep();
      csr_write(CSR_STEP_NUM, 36'd1);
      csr_write(CSR_EN_MASK, 36'hF);
      random_traffic(250);
      drain();
      csr_write(CSR_STEP_NUM, {STEP_W{1'b1}});
      csr_write(CSR_EN_MASK, 36'hA);
      random_traffic(250);
      drain();
      csr_write(CSR_STEP_NUM, STEP_W'({$urandom, $urandom}));
      csr_write(CSR_EN_MASK, '0);
      random_traffic(100);
      drain();
      csr_write(CSR_STEP_NUM, STEP_RESET);
      csr_write(CSR_EN_MASK, STEP_W'($urandom_range(0, 15)));
      random_traffic(250);
      drain();
      csr_write(CSR_EN_MASK, STEP_W'(MASK_RESET));
   endtask

   task automatic test_backpressure();
      int i;
      for (i = 0; i < NVOICE; i++) begin
         write_byte(16'h1000 + 16'(i), 8'($urandom));
         start_voice(i, 16'h1000, 16'd4, 16'd0, 16'd4);
         set_voice(i, 16'd200, 8'd50);
      end
      hold_request = 1'b1;
      repeat (30) render_frame();
      drain();
   endtask

   task automatic test_random();
      random_traffic(700);
      drain();
   endtask

   // receiver: random gaps plus one long hold on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 600;
      end
      if (hold_left > 0) begin
         rsp.ready = 1'b0;
         hold_left--;
      end else if (rsp_gap > 0) begin
         rsp.ready = 1'b0;
         rsp_gap--;
      end else begin
         rsp.ready = 1'b1;
         if (idle_on && $urandom_range(0, 2) == 0) rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      frame_type f;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected frame beat at %0t", $realtime);
         end else begin
            f = expected_frames.pop_front();
            if (f.left !== rsp.left_sample || f.right !== rsp.right_sample ||
                f.active !== rsp.active_mask) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("frame mismatch: exp L=%0d R=%0d M=%h got L=%0d R=%0d M=%h",
                           f.left, f.right, f.active, rsp.left_sample,
                           rsp.right_sample, rsp.active_mask);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles > STALL_LIMIT) begin
         $display("four_voice_sample_mixer_core regression: fail");
         $finish;
      end
   end

   initial begin
      int i;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.kind = KIND_WRITE;
      req.voice = '0;
      req.address = '0;
      req.data_byte = '0;
      req.length = '0;
      req.rpt_offset = '0;
      req.rpt_length = '0;
      req.period = '0;
      req.volume = '0;
      rsp.ready = 1'b0;
      mismatches = 0;
      items_sent = 0;
      idle_cycles = 0;
      idle_on = 1'b1;
      hold_request = 1'b0;
      hold_left = 0;
      rsp_gap = 0;
      for (i = 0; i < MEM_DEPTH; i++) begin
         mem_byte[i] = '0;
         mem_written[i] = 1'b0;
      end
      for (i = 0; i < NVOICE; i++) begin
         v_pos[i] = '0;
         v_base[i] = '0;
         v_end[i] = '0;
         v_lstart[i] = '0;
         v_llen[i] = '0;
         v_period[i] = '0;
         v_vol[i] = '0;
         v_active[i] = 1'b0;
      end
      step_num = STEP_RESET;
      en_mask = MASK_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_register_sweep();
      test_backpressure();
      test_random();
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("four_voice_sample_mixer_core regression: pass");
      else
         $display("four_voice_sample_mixer_core regression: fail");
      $finish;
   end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fvsm_pkg.sv
hw/rtl/fvsm_req_if.sv
hw/rtl/fvsm_rsp_if.sv
hw/rtl/fvsm_div.sv
hw/rtl/fvsm_sample_ram.sv
hw/rtl/four_voice_sample_mixer_core.sv
bench/tb.sv
